// ===== rtl/core/ptw2d_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw2d_pkg
// shared codes and fixed-point constants for the pointer-to-world pick
// ----------------------------------------------------------------------------
package ptw2d_pkg;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CONFIG   = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    REG_LOGICAL_EXTENT = 3'd0,
    REG_VIEWPORT_RECT  = 3'd1,
    REG_WORLD_EXTENT   = 3'd2,
    REG_CAMERA_CENTER  = 3'd3,
    REG_ROTATION       = 3'd4,
    REG_CAMERA_KEY     = 3'd5
  } reg_idx_t;

  localparam int unsigned DIV_STEPS = 30;
  localparam logic signed [30:0] HALF_Q30 = 31'sd536870912;
  localparam logic [16:0] UNIT_Q15 = 17'd32768;

endpackage

// ===== rtl/core/pointer_to_world_2d_pick.sv =====
// ----------------------------------------------------------------------------
// pointer_to_world_2d_pick
// maps a pointer position in window pixels to 2d world coordinates through
// a rotated orthographic camera
// ----------------------------------------------------------------------------
// usage:
//   in_*  beats carry pointer x/y (signed, COORD_FRAC_BITS fraction bits) and
//   three tags; out_* beats carry world x/y, the tags and the camera key,
//   with hit and error_code on out_tuser. one result beat per input beat.
//   cfg_* writes one register per cycle; write only while no beat is in flight.
// throughput: one beat per cycle while the output is not stalled. the depth is
//   set mostly by the 30-stage restoring divider that forms the viewport u/v.
// reset: config registers clear to zero (camera invalid), stage valids clear.
// stall: the whole pipeline holds while out_tvalid is high and out_tready low;
//   in_tready follows the same enable, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module pointer_to_world_2d_pick #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pointer_x, pointer_y, camera_revision, surface_revision, input_sequence
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // world_x, world_y, tag_camera_revision, tag_surface_revision,
  // tag_sequence, echo_camera_key
  output logic [191:0] out_tdata,
  // hit, error_code
  output logic [2:0]   out_tuser
);

  localparam int NW = 48 + COORD_FRAC_BITS;
  localparam int DS = int'(ptw2d_pkg::DIV_STEPS);
  localparam int NS = DS + 6;

  typedef struct packed {
    logic                   v;
    ptw2d_pkg::err_t        err;
    logic                   ins;
    logic [31:0]            tcr;
    logic [31:0]            tsr;
    logic [31:0]            tseq;
    logic signed [31:0]     px;
    logic signed [31:0]     py;
    logic [30:0]            lox;
    logic [30:0]            spx;
    logic [30:0]            loy;
    logic [30:0]            spy;
    logic [NW-1:0]          rx;
    logic [NW-1:0]          ry;
    logic [NW-1:0]          dx;
    logic [NW-1:0]          dy;
    logic [29:0]            qx;
    logic [29:0]            qy;
    logic signed [32:0]     lx;
    logic signed [32:0]     ly;
    logic signed [34:0]     m0;
    logic signed [34:0]     m1;
    logic signed [34:0]     m2;
    logic signed [34:0]     m3;
    logic [31:0]            wx;
    logic [31:0]            wy;
  } stage_t;

  logic [31:0] logical_extent_r;
  logic [63:0] viewport_rect_r;
  logic [63:0] world_extent_r;
  logic [63:0] camera_center_r;
  logic [63:0] rotation_r;
  logic [31:0] camera_key_r;

  stage_t st_r   [NS];
  stage_t st_nxt [NS];
  logic   en;

  logic [15:0] wwin, hwin, vl, vt, vw, vh;
  logic [31:0] ew, eh;
  logic signed [31:0] cx, cy, cs, sn;

  assign wwin = logical_extent_r[15:0];
  assign hwin = logical_extent_r[31:16];
  assign vl   = viewport_rect_r[15:0];
  assign vt   = viewport_rect_r[31:16];
  assign vw   = viewport_rect_r[47:32];
  assign vh   = viewport_rect_r[63:48];
  assign ew   = world_extent_r[31:0];
  assign eh   = world_extent_r[63:32];
  assign cx   = $signed(camera_center_r[31:0]);
  assign cy   = $signed(camera_center_r[63:32]);
  assign cs   = $signed(rotation_r[31:0]);
  assign sn   = $signed(rotation_r[63:32]);

  assign en        = !st_r[NS-1].v || out_tready;
  assign in_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logical_extent_r <= '0;
      viewport_rect_r  <= '0;
      world_extent_r   <= '0;
      camera_center_r  <= '0;
      rotation_r       <= '0;
      camera_key_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptw2d_pkg::REG_LOGICAL_EXTENT: logical_extent_r <= cfg_wdata[31:0];
        ptw2d_pkg::REG_VIEWPORT_RECT:  viewport_rect_r  <= cfg_wdata;
        ptw2d_pkg::REG_WORLD_EXTENT:   world_extent_r   <= cfg_wdata;
        ptw2d_pkg::REG_CAMERA_CENTER:  camera_center_r  <= cfg_wdata;
        ptw2d_pkg::REG_ROTATION:       rotation_r       <= cfg_wdata;
        ptw2d_pkg::REG_CAMERA_KEY:     camera_key_r     <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stage_t p;
    logic bad;
    logic signed [NW-1:0] sx, sy, lo_x, lo_y, hi_x, hi_y;
    logic [NW-1:0] tx, ty;
    logic signed [30:0] cu, cv;
    logic signed [63:0] pl0, pl1;
    logic signed [64:0] r0, r1, r2, r3;
    logic signed [35:0] wxs, wys;
    logic ovf;

    // stage 0: capture
    st_nxt[0]      = st_r[0];
    st_nxt[0].v    = in_tvalid;
    st_nxt[0].px   = $signed(in_tdata[31:0]);
    st_nxt[0].py   = $signed(in_tdata[63:32]);
    st_nxt[0].tcr  = in_tdata[95:64];
    st_nxt[0].tsr  = in_tdata[127:96];
    st_nxt[0].tseq = in_tdata[159:128];

    // stage 1: config check, viewport bounds in Q15 pixel units
    p   = st_r[0];
    bad = (camera_key_r == 32'd0) || (wwin == 16'd0) || (hwin == 16'd0) ||
          (ew == 32'd0) || (eh == 32'd0) || (vw == 16'd0) || (vh == 16'd0) ||
          ((17'(vl) + 17'(vw)) > ptw2d_pkg::UNIT_Q15) ||
          ((17'(vt) + 17'(vh)) > ptw2d_pkg::UNIT_Q15);
    p.err = bad ? ptw2d_pkg::ERR_CONFIG : ptw2d_pkg::ERR_NONE;
    p.lox = 31'(32'(vl) * 32'(wwin));
    p.spx = 31'(32'(vw) * 32'(wwin));
    p.loy = 31'(32'(vt) * 32'(hwin));
    p.spy = 31'(32'(vh) * 32'(hwin));
    st_nxt[1] = p;

    // stage 2: viewport membership, divider setup
    p    = st_r[1];
    sx   = NW'(p.px) <<< 15;
    sy   = NW'(p.py) <<< 15;
    lo_x = $signed(NW'({p.lox, COORD_FRAC_BITS'(0)}));
    lo_y = $signed(NW'({p.loy, COORD_FRAC_BITS'(0)}));
    hi_x = lo_x + $signed(NW'({p.spx, COORD_FRAC_BITS'(0)}));
    hi_y = lo_y + $signed(NW'({p.spy, COORD_FRAC_BITS'(0)}));
    p.ins = (p.err == ptw2d_pkg::ERR_NONE) && (sx >= lo_x) && (sy >= lo_y) &&
            (sx < hi_x) && (sy < hi_y);
    p.rx = NW'(sx - lo_x);
    p.ry = NW'(sy - lo_y);
    p.dx = NW'({p.spx, COORD_FRAC_BITS'(0)});
    p.dy = NW'({p.spy, COORD_FRAC_BITS'(0)});
    p.qx = '0;
    p.qy = '0;
    st_nxt[2] = p;

    // stages 3 .. DS+2: one restoring division step each
    for (int k = 0; k < DS; k++) begin
      p  = st_r[k+2];
      tx = p.rx << 1;
      ty = p.ry << 1;
      if (tx >= p.dx) begin
        p.rx = tx - p.dx;
        p.qx = {p.qx[28:0], 1'b1};
      end else begin
        p.rx = tx;
        p.qx = {p.qx[28:0], 1'b0};
      end
      if (ty >= p.dy) begin
        p.ry = ty - p.dy;
        p.qy = {p.qy[28:0], 1'b1};
      end else begin
        p.ry = ty;
        p.qy = {p.qy[28:0], 1'b0};
      end
      st_nxt[k+3] = p;
    end

    // centre and scale to camera-local coordinates
    p    = st_r[DS+2];
    cu   = $signed({1'b0, p.qx}) - ptw2d_pkg::HALF_Q30;
    cv   = ptw2d_pkg::HALF_Q30 - $signed({1'b0, p.qy});
    pl0  = 64'(cu) * 64'($signed({1'b0, ew}));
    pl1  = 64'(cv) * 64'($signed({1'b0, eh}));
    p.lx = 33'(pl0 >>> 30);
    p.ly = 33'(pl1 >>> 30);
    st_nxt[DS+3] = p;

    // rotation products
    p    = st_r[DS+3];
    r0   = 65'(cs) * 65'(p.lx);
    r1   = 65'(sn) * 65'(p.ly);
    r2   = 65'(sn) * 65'(p.lx);
    r3   = 65'(cs) * 65'(p.ly);
    p.m0 = 35'(r0 >>> 30);
    p.m1 = 35'(r1 >>> 30);
    p.m2 = 35'(r2 >>> 30);
    p.m3 = 35'(r3 >>> 30);
    st_nxt[DS+4] = p;

    // offset, overflow check, result
    p   = st_r[DS+4];
    wxs = 36'(cx) + 36'(p.m0) - 36'(p.m1);
    wys = 36'(cy) + 36'(p.m2) + 36'(p.m3);
    ovf = (wxs[35:31] != {5{wxs[31]}}) || (wys[35:31] != {5{wys[31]}});
    p.wx = '0;
    p.wy = '0;
    if (p.ins) begin
      if (ovf) begin
        p.ins = 1'b0;
        p.err = ptw2d_pkg::ERR_OVERFLOW;
      end else begin
        p.wx = wxs[31:0];
        p.wy = wys[31:0];
      end
    end
    st_nxt[DS+5] = p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        st_r[i].v <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < NS; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_tvalid = st_r[NS-1].v;
  assign out_tdata  = {camera_key_r, st_r[NS-1].tseq, st_r[NS-1].tsr,
                       st_r[NS-1].tcr, st_r[NS-1].wy, st_r[NS-1].wx};
  assign out_tuser  = {st_r[NS-1].err, st_r[NS-1].ins};

endmodule
